// ----- hw/rtl/bpa_pkg.sv -----
// shared constants and codes for the buddy page allocator
package bpa_pkg;

	// default geometry
	localparam int MAX_ORDERS_DEF = 11;
	localparam int PAGE_BYTES_DEF = 4096;

	// payload widths
	localparam int MODE_W   = 2;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 2;
	localparam int ORDER_W  = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'h3C00_0000;

	// tree entry codes
	localparam logic [1:0] ST_COVERED = 2'd0;
	localparam logic [1:0] ST_FREE    = 2'd1;
	localparam logic [1:0] ST_ALLOC   = 2'd2;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BAD     = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_FREE  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_RNG  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

endpackage

// ----- hw/rtl/bpa_if.sv -----
// request and result channel interfaces
interface bpa_in_if;
	import bpa_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] request_bytes;
	logic [ADDR_W-1:0] address;
	logic [ADDR_W-1:0] end_address;
	modport source (output valid, mode, request_bytes, address, end_address, input ready);
	modport sink (input valid, mode, request_bytes, address, end_address, output ready);
endinterface

interface bpa_out_if;
	import bpa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   block_address;
	logic [ORDER_W-1:0]  block_order;
	modport source (output valid, status, block_address, block_order, input ready);
	modport sink (input valid, status, block_address, block_order, output ready);
endinterface

// ----- hw/rtl/bpa_ram.sv -----
// generic single-write, single-read ram with registered read
module bpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2047
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/bpa_lowest.sv -----
// scanner that rebuilds the lowest free page index of every order
module bpa_lowest #(
	parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	output logic [MAX_ORDERS-1:0]                  raddr,
	input  logic [1:0]                             rdata,
	output logic [MAX_ORDERS-1:0]                  lf_valid,
	output logic [MAX_ORDERS-1:0][MAX_ORDERS-2:0]  lf_idx
);
	import bpa_pkg::*;

	localparam int PW    = MAX_ORDERS - 1;
	localparam int AW    = MAX_ORDERS;
	localparam int OW    = $clog2(MAX_ORDERS);
	localparam int PAGES = 1 << PW;
	localparam int TREE  = (1 << MAX_ORDERS) - 1;

	logic          issuing_q;
	logic [AW-1:0] s_q;
	logic [OW-1:0] o_q;
	logic [PW-1:0] off_q;
	logic          vld_s1;
	logic [OW-1:0] o_s1;
	logic [PW-1:0] off_s1;
	logic [PW-1:0] last_off;

	// last entry offset of the order being walked
	assign last_off = PW'(PAGES - 1) >> o_q;
	assign raddr    = s_q;
	assign busy     = issuing_q | vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			s_q       <= '0;
			o_q       <= '0;
			off_q     <= '0;
			vld_s1    <= 1'b0;
			o_s1      <= '0;
			off_s1    <= '0;
			lf_valid  <= '0;
			lf_idx    <= '0;
		end else begin
			vld_s1 <= issuing_q;
			o_s1   <= o_q;
			off_s1 <= off_q;
			if (start) begin
				issuing_q <= 1'b1;
				s_q       <= '0;
				o_q       <= '0;
				off_q     <= '0;
				lf_valid  <= '0;
			end else if (issuing_q) begin
				if (s_q == AW'(TREE - 1)) begin
					issuing_q <= 1'b0;
				end
				s_q <= s_q + AW'(1);
				if (off_q == last_off) begin
					o_q   <= o_q + OW'(1);
					off_q <= '0;
				end else begin
					off_q <= off_q + PW'(1);
				end
			end
			if (vld_s1 && rdata == ST_FREE && !lf_valid[o_s1]) begin
				lf_valid[o_s1] <= 1'b1;
				lf_idx[o_s1]   <= off_s1 << o_s1;
			end
		end
	end
endmodule

// ----- hw/rtl/buddy_page_allocator_top.sv -----
// top level of the buddy page allocator: sequencer around the status tree ram
//
// The block manages 2^(MAX_ORDERS-1) pages of PAGE_BYTES bytes starting at
// base_address. All block state sits in one 2-bit status ram holding one tree
// level per order (2^MAX_ORDERS - 1 entries in all) plus a small table of the
// lowest free page per order. After reset the block sweeps the ram once, one
// entry a cycle, and then rebuilds the lowest-free table; no item is taken
// meanwhile. Items are handled one at a time. Every item that changes state
// ends with a rescan of the whole ram, one entry a cycle. Allocate looks for
// the smallest fitting order with a free block, splits it down level by level
// and marks the entries below the block allocated. Free probes the orders
// upward for the allocated block, clears the entries below it and merges
// upward while the buddy is free. Reserve marks every page of the range at
// every order. Items that fail a range or size check skip the walk and the
// rescan. The result sits in an output register, so the next item is taken
// while it waits. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module buddy_page_allocator_top #(
	parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpa_pkg::ADDR_W-1:0]     cfg_data,
	bpa_in_if.sink                         in_ch,
	bpa_out_if.source                      out_ch
);
	import bpa_pkg::*;

	localparam int PW    = MAX_ORDERS - 1;        // page index bits
	localparam int AW    = MAX_ORDERS;            // tree ram address bits
	localparam int OW    = $clog2(MAX_ORDERS);    // order counter bits
	localparam int PAGES = 1 << PW;
	localparam int TREE  = (1 << MAX_ORDERS) - 1;
	localparam int PBL   = $clog2(PAGE_BYTES);
	localparam logic [33:0] TOTAL_BYTES = 34'(PAGE_BYTES) * 34'(PAGES);

	// sequencer states
	localparam int SW = 5;
	localparam logic [SW-1:0] S_CLR     = 5'd0;
	localparam logic [SW-1:0] S_IDLE    = 5'd1;
	localparam logic [SW-1:0] S_A_FIND  = 5'd2;
	localparam logic [SW-1:0] S_A_TOP   = 5'd3;
	localparam logic [SW-1:0] S_A_SRD   = 5'd4;
	localparam logic [SW-1:0] S_A_SWR   = 5'd5;
	localparam logic [SW-1:0] S_A_SSELF = 5'd6;
	localparam logic [SW-1:0] S_A_FRD   = 5'd7;
	localparam logic [SW-1:0] S_A_FWR   = 5'd8;
	localparam logic [SW-1:0] S_F_CRD   = 5'd9;
	localparam logic [SW-1:0] S_F_CHK   = 5'd10;
	localparam logic [SW-1:0] S_F_POST  = 5'd11;
	localparam logic [SW-1:0] S_F_CLR   = 5'd12;
	localparam logic [SW-1:0] S_F_SELF  = 5'd13;
	localparam logic [SW-1:0] S_F_MRD   = 5'd14;
	localparam logic [SW-1:0] S_F_MCHK  = 5'd15;
	localparam logic [SW-1:0] S_F_MBUD  = 5'd16;
	localparam logic [SW-1:0] S_R_WR    = 5'd17;
	localparam logic [SW-1:0] S_R_CHK   = 5'd18;
	localparam logic [SW-1:0] S_SCAN_GO = 5'd19;
	localparam logic [SW-1:0] S_SCAN_WT = 5'd20;
	localparam logic [SW-1:0] S_DONE    = 5'd21;

	// configuration registers
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] limit_q;

	// sequencer state
	logic [SW-1:0]       state_q;
	logic [AW-1:0]       clr_q;
	logic                op_q;      // scan belongs to an item, not to reset
	logic [OW-1:0]       k_q;       // order being walked
	logic [OW-1:0]       ord_q;     // order of the result block
	logic [PW-1:0]       a_q;       // block page index
	logic [PW:0]         m_q;       // page offset inside the block
	logic [PW:0]         c_q;       // reserve page counter
	logic [PW:0]         si_q;
	logic [PW:0]         hi_q;
	logic [ADDR_W-1:0]   req_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [ORDER_W-1:0]  out_order_q;

	// ram ports
	logic          we;
	logic [AW-1:0] waddr;
	logic [1:0]    wdata;
	logic [AW-1:0] seq_raddr;
	logic [AW-1:0] scan_raddr;
	logic [AW-1:0] raddr;
	logic [1:0]    rdata;

	// lowest free table
	logic                          scan_start;
	logic                          scan_busy;
	logic [MAX_ORDERS-1:0]         lf_valid;
	logic [MAX_ORDERS-1:0][PW-1:0] lf_idx;

	// request decode
	logic              in_acc;
	logic [ADDR_W-1:0] f_diff;
	logic [ADDR_W-1:0] f_idx_full;
	logic              f_bad;
	logic [ADDR_W-1:0] r_sdiff;
	logic [ADDR_W-1:0] r_ediff;
	logic [ADDR_W:0]   r_si;
	logic [ADDR_W:0]   r_ei;
	logic [PW:0]       r_hi;
	logic              r_bad;
	logic              out_load;

	// walk helpers
	logic [PW:0]   pw_k;
	logic [PW:0]   m_next;
	logic [PW:0]   c_next;
	logic [PW-1:0] bud_k;
	logic          last_ord;

	// tree ram slot of a page at an order
	function automatic logic [AW-1:0] slot(input logic [OW-1:0] o, input logic [PW-1:0] p);
		logic [AW:0] b;
		b = (AW+1)'(1) << AW;
		b = b - ((AW+1)'(1) << (AW - int'(o)));
		return b[AW-1:0] + AW'(p >> o);
	endfunction

	// block of this order is the smallest that holds the request
	function automatic logic leaf(input logic [OW-1:0] o, input logic [ADDR_W-1:0] req);
		logic [33:0] sz;
		sz = 34'(PAGE_BYTES) << o;
		return (o == '0) || ((sz >> 1) < 34'(req));
	endfunction

	function automatic logic fits(input logic [OW-1:0] o, input logic [ADDR_W-1:0] req);
		logic [33:0] sz;
		sz = 34'(PAGE_BYTES) << o;
		return sz >= 34'(req);
	endfunction

	// address of a page inside the managed area
	function automatic logic [ADDR_W-1:0] page_addr(input logic [ADDR_W-1:0] b,
			input logic [PW-1:0] p);
		return b + (ADDR_W'(p) << PBL);
	endfunction

	assign in_acc = in_ch.valid & in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	// free: page index of the address
	assign f_diff     = in_ch.address - base_q;
	assign f_idx_full = f_diff >> PBL;
	assign f_bad      = (in_ch.address < base_q) || (f_idx_full >= ADDR_W'(PAGES));

	// reserve: page range, a partial last page counts
	assign r_sdiff = in_ch.address - base_q;
	assign r_ediff = in_ch.end_address - base_q;
	assign r_si    = (ADDR_W+1)'(r_sdiff >> PBL);
	assign r_ei    = (ADDR_W+1)'(r_ediff >> PBL)
		+ (ADDR_W+1)'(in_ch.end_address[PBL-1:0] != '0);
	assign r_hi    = (r_ei < (ADDR_W+1)'(PAGES)) ? r_ei[PW:0] : (PW+1)'(PAGES);
	assign r_bad   = (in_ch.address < base_q) || (in_ch.end_address > limit_q)
		|| (in_ch.end_address < base_q) || (r_ei < r_si);

	assign pw_k     = (PW+1)'(1) << k_q;
	assign bud_k    = pw_k[PW-1:0];
	assign m_next   = m_q + pw_k;
	assign c_next   = c_q + (PW+1)'(1);
	assign last_ord = (k_q == OW'(MAX_ORDERS - 1));

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// ram access per state
	always_comb begin
		we         = 1'b0;
		waddr      = '0;
		wdata      = ST_COVERED;
		seq_raddr  = '0;
		scan_start = 1'b0;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				// the single top-order block starts free
				wdata = (clr_q == AW'(TREE - 1)) ? ST_FREE : ST_COVERED;
			end
			S_A_TOP: begin
				we    = 1'b1;
				waddr = slot(k_q, a_q);
				wdata = leaf(k_q, req_q) ? ST_ALLOC : ST_COVERED;
			end
			S_A_SRD: begin
				seq_raddr = slot(k_q, a_q + bud_k);
			end
			S_A_SWR: begin
				// upper half of the split becomes free
				we    = (rdata == ST_COVERED);
				waddr = slot(k_q, a_q + bud_k);
				wdata = ST_FREE;
			end
			S_A_SSELF: begin
				we    = 1'b1;
				waddr = slot(k_q, a_q);
				wdata = leaf(k_q, req_q) ? ST_ALLOC : ST_COVERED;
			end
			S_A_FRD: begin
				seq_raddr = slot(k_q, a_q + m_q[PW-1:0]);
			end
			S_A_FWR: begin
				we    = (rdata == ST_COVERED);
				waddr = slot(k_q, a_q + m_q[PW-1:0]);
				wdata = ST_ALLOC;
			end
			S_F_CRD: begin
				seq_raddr = slot(k_q, a_q);
			end
			S_F_CLR: begin
				we    = 1'b1;
				waddr = slot(k_q, a_q + m_q[PW-1:0]);
				wdata = ST_COVERED;
			end
			S_F_SELF: begin
				we    = 1'b1;
				waddr = slot(ord_q, a_q);
				wdata = ST_FREE;
			end
			S_F_MRD: begin
				if (last_ord) begin
					we    = 1'b1;
					waddr = slot(k_q, a_q);
					wdata = ST_FREE;
				end else begin
					seq_raddr = slot(k_q, a_q ^ bud_k);
				end
			end
			S_F_MCHK: begin
				// free buddy: both merge into the parent
				we    = 1'b1;
				waddr = slot(k_q, a_q);
				wdata = (rdata == ST_FREE) ? ST_COVERED : ST_FREE;
			end
			S_F_MBUD: begin
				we    = 1'b1;
				waddr = slot(k_q, a_q ^ bud_k);
				wdata = ST_COVERED;
			end
			S_R_WR: begin
				we        = 1'b1;
				waddr     = slot(k_q, c_q[PW-1:0]);
				wdata     = ST_ALLOC;
				seq_raddr = slot(k_q, c_q[PW-1:0] ^ bud_k);
			end
			S_R_CHK: begin
				we    = (rdata == ST_COVERED);
				waddr = slot(k_q, c_q[PW-1:0] ^ bud_k);
				wdata = ST_FREE;
			end
			S_SCAN_GO: begin
				scan_start = 1'b1;
			end
			default: ;
		endcase
	end

	assign raddr = scan_busy ? scan_raddr : seq_raddr;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			op_q         <= 1'b0;
			k_q          <= '0;
			ord_q        <= '0;
			a_q          <= '0;
			m_q          <= '0;
			c_q          <= '0;
			si_q         <= '0;
			hi_q         <= '0;
			req_q        <= '0;
			res_status_q <= STAT_OK;
			res_addr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TREE - 1)) begin
						op_q    <= 1'b0;
						state_q <= S_SCAN_GO;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						op_q         <= 1'b1;
						k_q          <= '0;
						ord_q        <= '0;
						m_q          <= '0;
						res_status_q <= STAT_OK;
						res_addr_q   <= '0;
						req_q        <= in_ch.request_bytes;
						unique case (in_ch.mode)
							MODE_ALLOC: begin
								if (34'(in_ch.request_bytes) > TOTAL_BYTES) begin
									res_status_q <= STAT_TOO_BIG;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_A_FIND;
								end
							end
							MODE_FREE: begin
								if (f_bad) begin
									res_status_q <= STAT_BAD_RNG;
									state_q      <= S_DONE;
								end else begin
									a_q        <= f_idx_full[PW-1:0];
									res_addr_q <= page_addr(base_q, f_idx_full[PW-1:0]);
									state_q    <= S_F_CRD;
								end
							end
							MODE_RESERVE: begin
								if (r_bad) begin
									res_status_q <= STAT_BAD_RNG;
									state_q      <= S_DONE;
								end else if (r_si < (ADDR_W+1)'(r_hi)) begin
									si_q    <= r_si[PW:0];
									c_q     <= r_si[PW:0];
									hi_q    <= r_hi;
									state_q <= S_R_WR;
								end else begin
									// range is empty or lies past the managed pages
									state_q <= S_SCAN_GO;
								end
							end
							MODE_BAD: begin
								res_status_q <= STAT_BAD_RNG;
								state_q      <= S_DONE;
							end
							default: ;
						endcase
					end
				end
				// allocate: smallest fitting order with a free block
				S_A_FIND: begin
					if (fits(k_q, req_q) && lf_valid[k_q]) begin
						a_q        <= lf_idx[k_q];
						res_addr_q <= page_addr(base_q, lf_idx[k_q]);
						state_q    <= S_A_TOP;
					end else if (last_ord) begin
						res_status_q <= STAT_NO_FREE;
						state_q      <= S_DONE;
					end else begin
						k_q <= k_q + OW'(1);
					end
				end
				S_A_TOP, S_A_SSELF: begin
					if (leaf(k_q, req_q)) begin
						ord_q <= k_q;
						k_q   <= '0;
						m_q   <= '0;
						state_q <= (k_q == '0) ? S_SCAN_GO : S_A_FRD;
					end else begin
						k_q     <= k_q - OW'(1);
						state_q <= S_A_SRD;
					end
				end
				S_A_SRD: state_q <= S_A_SWR;
				S_A_SWR: state_q <= S_A_SSELF;
				// mark the lower orders under the new block allocated
				S_A_FRD: state_q <= S_A_FWR;
				S_A_FWR: begin
					if (m_next >= ((PW+1)'(1) << ord_q)) begin
						m_q <= '0;
						if (k_q + OW'(1) == ord_q) begin
							state_q <= S_SCAN_GO;
						end else begin
							k_q     <= k_q + OW'(1);
							state_q <= S_A_FRD;
						end
					end else begin
						m_q     <= m_next;
						state_q <= S_A_FRD;
					end
				end
				// free: find the order of the allocated block
				S_F_CRD: begin
					if ((({1'b0, a_q}) & (pw_k - (PW+1)'(1))) == '0) begin
						state_q <= S_F_CHK;
					end else begin
						state_q <= S_F_POST;
					end
				end
				S_F_CHK: begin
					if (rdata == ST_ALLOC) begin
						ord_q <= k_q;
						if (last_ord) begin
							state_q <= S_F_POST;
						end else begin
							k_q     <= k_q + OW'(1);
							state_q <= S_F_CRD;
						end
					end else begin
						state_q <= S_F_POST;
					end
				end
				S_F_POST: begin
					k_q <= '0;
					m_q <= '0;
					state_q <= (ord_q == '0) ? S_F_SELF : S_F_CLR;
				end
				S_F_CLR: begin
					if (m_next >= ((PW+1)'(1) << ord_q)) begin
						m_q <= '0;
						if (k_q + OW'(1) == ord_q) begin
							state_q <= S_F_SELF;
						end else begin
							k_q <= k_q + OW'(1);
						end
					end else begin
						m_q <= m_next;
					end
				end
				S_F_SELF: begin
					k_q     <= ord_q;
					state_q <= S_F_MRD;
				end
				// merge upward while the buddy is free
				S_F_MRD: state_q <= last_ord ? S_SCAN_GO : S_F_MCHK;
				S_F_MCHK: state_q <= (rdata == ST_FREE) ? S_F_MBUD : S_SCAN_GO;
				S_F_MBUD: begin
					k_q     <= k_q + OW'(1);
					state_q <= S_F_MRD;
				end
				// reserve: every page of the range at every order
				S_R_WR, S_R_CHK: begin
					if (state_q == S_R_WR && !last_ord) begin
						state_q <= S_R_CHK;
					end else if (c_next == hi_q) begin
						c_q <= si_q;
						if (last_ord) begin
							state_q <= S_SCAN_GO;
						end else begin
							k_q     <= k_q + OW'(1);
							state_q <= S_R_WR;
						end
					end else begin
						c_q     <= c_next;
						state_q <= S_R_WR;
					end
				end
				S_SCAN_GO: state_q <= S_SCAN_WT;
				S_SCAN_WT: begin
					if (!scan_busy) begin
						state_q <= op_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= (res_status_q == STAT_OK) ? res_addr_q : '0;
			out_order_q  <= (res_status_q == STAT_OK) ? ORDER_W'(ord_q) : '0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.block_address = out_addr_q;
	assign out_ch.block_order   = out_order_q;

	bpa_ram #(
		.WIDTH (2),
		.DEPTH (TREE)
	) u_tree (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bpa_lowest #(
		.MAX_ORDERS (MAX_ORDERS)
	) u_lowest (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.busy     (scan_busy),
		.raddr    (scan_raddr),
		.rdata    (rdata),
		.lf_valid (lf_valid),
		.lf_idx   (lf_idx)
	);
endmodule
